/* rtl/core/trls_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trls_pkg
// Shared constants, types and the step program of the two-parameter RLS
// estimator.
// ----------------------------------------------------------------------------
package trls_pkg;

  localparam int DataW    = 32;
  localparam int StateW   = 48;
  localparam int HalfW    = StateW / 2;
  localparam int DataFrac = DataW / 2;
  localparam int FfW      = 17;
  localparam int CovW     = DataW - 1;
  localparam int RfDepth  = 16;
  localparam int RfAw     = 4;
  localparam int PcW      = 6;
  localparam int InitW    = 3;
  localparam int CfgAw    = 4;

  localparam logic [PcW-1:0]   ProgLast = 6'd35;
  localparam logic [InitW-1:0] InitLast = 3'd5;

  localparam logic [1:0] CFG_FF     = 2'd0;
  localparam logic [1:0] CFG_COV    = 2'd1;
  localparam logic [1:0] CFG_OFFSET = 2'd2;

  localparam logic [FfW-1:0]   FfReset     = 17'd64881;
  localparam logic [CovW-1:0]  CovReset    = 31'd65536000;
  localparam logic [DataW-1:0] OffsetReset = 32'd6750208;

  localparam logic [RfAw-1:0] R_P0    = 4'd0;
  localparam logic [RfAw-1:0] R_P1    = 4'd1;
  localparam logic [RfAw-1:0] R_P2    = 4'd2;
  localparam logic [RfAw-1:0] R_P3    = 4'd3;
  localparam logic [RfAw-1:0] R_C0    = 4'd4;
  localparam logic [RfAw-1:0] R_C1    = 4'd5;
  localparam logic [RfAw-1:0] R_PPHI0 = 4'd6;
  localparam logic [RfAw-1:0] R_PPHI1 = 4'd7;
  localparam logic [RfAw-1:0] R_COL0  = 4'd8;
  localparam logic [RfAw-1:0] R_COL1  = 4'd9;
  localparam logic [RfAw-1:0] R_DEN   = 4'd10;
  localparam logic [RfAw-1:0] R_K0    = 4'd11;
  localparam logic [RfAw-1:0] R_K1    = 4'd12;
  localparam logic [RfAw-1:0] R_ERR   = 4'd13;
  localparam logic [RfAw-1:0] R_T0    = 4'd14;
  localparam logic [RfAw-1:0] R_T1    = 4'd15;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_RSUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [2:0] {
    B_MEM,
    B_PHI0,
    B_PHI1,
    B_Y,
    B_LAM,
    B_FF
  } bsel_t;

  typedef struct packed {
    op_t            op;
    logic [RfAw-1:0] ra;
    logic [RfAw-1:0] rb;
    bsel_t          bsel;
    logic [RfAw-1:0] dest;
    logic           s24;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic exec;
    logic init_wr;
    logic load_in;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  function automatic uop_t mk(op_t op, logic [RfAw-1:0] ra, logic [RfAw-1:0] rb,
                              bsel_t bsel, logic [RfAw-1:0] dest, logic s24);
    uop_t u;
    u.op   = op;
    u.ra   = ra;
    u.rb   = rb;
    u.bsel = bsel;
    u.dest = dest;
    u.s24  = s24;
    return u;
  endfunction

  function automatic uop_t prog_rom(logic [PcW-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_MUL,  R_P0,    R_T0,  B_PHI0, R_T0,    1'b0);
      6'd1:  u = mk(OP_MUL,  R_P1,    R_T0,  B_PHI1, R_T1,    1'b0);
      6'd2:  u = mk(OP_ADD,  R_T0,    R_T1,  B_MEM,  R_PPHI0, 1'b0);
      6'd3:  u = mk(OP_MUL,  R_P2,    R_T0,  B_PHI1, R_T1,    1'b0);
      6'd4:  u = mk(OP_ADD,  R_T0,    R_T1,  B_MEM,  R_COL0,  1'b0);
      6'd5:  u = mk(OP_MUL,  R_P2,    R_T0,  B_PHI0, R_T0,    1'b0);
      6'd6:  u = mk(OP_MUL,  R_P3,    R_T0,  B_PHI1, R_T1,    1'b0);
      6'd7:  u = mk(OP_ADD,  R_T0,    R_T1,  B_MEM,  R_PPHI1, 1'b0);
      6'd8:  u = mk(OP_MUL,  R_P1,    R_T0,  B_PHI0, R_T0,    1'b0);
      6'd9:  u = mk(OP_ADD,  R_T0,    R_T1,  B_MEM,  R_COL1,  1'b0);
      6'd10: u = mk(OP_MUL,  R_PPHI0, R_T0,  B_PHI0, R_T0,    1'b0);
      6'd11: u = mk(OP_MUL,  R_PPHI1, R_T0,  B_PHI1, R_T1,    1'b0);
      6'd12: u = mk(OP_ADD,  R_T0,    R_T1,  B_MEM,  R_T0,    1'b0);
      6'd13: u = mk(OP_ADD,  R_T0,    R_T0,  B_LAM,  R_DEN,   1'b0);
      6'd14: u = mk(OP_DIV,  R_PPHI0, R_DEN, B_MEM,  R_K0,    1'b1);
      6'd15: u = mk(OP_DIV,  R_PPHI1, R_DEN, B_MEM,  R_K1,    1'b1);
      6'd16: u = mk(OP_MUL,  R_C0,    R_T0,  B_PHI0, R_T0,    1'b0);
      6'd17: u = mk(OP_MUL,  R_C1,    R_T0,  B_PHI1, R_T1,    1'b0);
      6'd18: u = mk(OP_ADD,  R_T0,    R_T1,  B_MEM,  R_T0,    1'b0);
      6'd19: u = mk(OP_RSUB, R_T0,    R_T0,  B_Y,    R_ERR,   1'b0);
      6'd20: u = mk(OP_MUL,  R_K0,    R_ERR, B_MEM,  R_T0,    1'b1);
      6'd21: u = mk(OP_ADD,  R_C0,    R_T0,  B_MEM,  R_C0,    1'b0);
      6'd22: u = mk(OP_MUL,  R_K1,    R_ERR, B_MEM,  R_T0,    1'b1);
      6'd23: u = mk(OP_ADD,  R_C1,    R_T0,  B_MEM,  R_C1,    1'b0);
      6'd24: u = mk(OP_MUL,  R_K0,    R_COL0, B_MEM, R_T0,    1'b1);
      6'd25: u = mk(OP_SUB,  R_P0,    R_T0,  B_MEM,  R_T0,    1'b0);
      6'd26: u = mk(OP_DIV,  R_T0,    R_T0,  B_FF,   R_P0,    1'b0);
      6'd27: u = mk(OP_MUL,  R_K0,    R_COL1, B_MEM, R_T0,    1'b1);
      6'd28: u = mk(OP_SUB,  R_P1,    R_T0,  B_MEM,  R_T0,    1'b0);
      6'd29: u = mk(OP_DIV,  R_T0,    R_T0,  B_FF,   R_P1,    1'b0);
      6'd30: u = mk(OP_MUL,  R_K1,    R_COL0, B_MEM, R_T0,    1'b1);
      6'd31: u = mk(OP_SUB,  R_P2,    R_T0,  B_MEM,  R_T0,    1'b0);
      6'd32: u = mk(OP_DIV,  R_T0,    R_T0,  B_FF,   R_P2,    1'b0);
      6'd33: u = mk(OP_MUL,  R_K1,    R_COL1, B_MEM, R_T0,    1'b1);
      6'd34: u = mk(OP_SUB,  R_P3,    R_T0,  B_MEM,  R_T0,    1'b0);
      6'd35: u = mk(OP_DIV,  R_T0,    R_T0,  B_FF,   R_P3,    1'b0);
      default: u = mk(OP_ADD, R_T0,   R_T0,  B_MEM,  R_T0,    1'b0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/trls_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trls_regs
// Configuration register block: forgetting factor, initial covariance and
// power offset, with a reinitialization pulse on every listed write.
// ----------------------------------------------------------------------------
module trls_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [trls_pkg::CfgAw-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  output logic [trls_pkg::FfW-1:0]   ff,
  output logic [trls_pkg::CovW-1:0]  init_cov,
  output logic [trls_pkg::DataW-1:0] offset,
  output logic                       reinit
);
  import trls_pkg::*;

  logic [FfW-1:0]   ff_r, ff_nxt;
  logic [CovW-1:0]  cov_r, cov_nxt;
  logic [DataW-1:0] off_r, off_nxt;
  logic             wr;
  logic [1:0]       idx;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[3:2];

  always_comb begin
    ff_nxt  = ff_r;
    cov_nxt = cov_r;
    off_nxt = off_r;
    reinit  = 1'b0;
    if (wr) begin
      unique case (idx)
        CFG_FF: begin
          ff_nxt = cfg_pwdata[FfW-1:0];
          reinit = 1'b1;
        end
        CFG_COV: begin
          cov_nxt = cfg_pwdata[CovW-1:0];
          reinit  = 1'b1;
        end
        CFG_OFFSET: begin
          off_nxt = cfg_pwdata[DataW-1:0];
          reinit  = 1'b1;
        end
        default: reinit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_r  <= FfReset;
      cov_r <= CovReset;
      off_r <= OffsetReset;
    end else begin
      ff_r  <= ff_nxt;
      cov_r <= cov_nxt;
      off_r <= off_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      CFG_FF:     cfg_prdata = {{(32-FfW){1'b0}}, ff_r};
      CFG_COV:    cfg_prdata = {{(32-CovW){1'b0}}, cov_r};
      CFG_OFFSET: cfg_prdata = off_r;
      default:    cfg_prdata = '0;
    endcase
  end

  assign ff       = ff_r;
  assign init_cov = cov_r;
  assign offset   = off_r;

endmodule
`default_nettype wire

/* rtl/core/trls_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trls_datapath
// Register file, saturating adder, two-pass 48x24 multiplier and radix-4
// restoring divider of the RLS estimator, plus the result registers.
// ----------------------------------------------------------------------------
module trls_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  trls_pkg::dp_cmd_t                 cmd,
  output trls_pkg::dp_stat_t                stat,
  input  logic [trls_pkg::FfW-1:0]          ff,
  input  logic [trls_pkg::CovW-1:0]         init_cov,
  input  logic [trls_pkg::DataW-1:0]        offset,
  input  logic signed [trls_pkg::DataW-1:0] abs_in,
  input  logic signed [trls_pkg::DataW-1:0] tsq_in,
  input  logic signed [trls_pkg::DataW-1:0] base_in,
  input  logic signed [trls_pkg::DataW-1:0] meas_in,
  output logic signed [trls_pkg::StateW-1:0] coeff_one,
  output logic signed [trls_pkg::StateW-1:0] coeff_two,
  output logic signed [trls_pkg::DataW-1:0]  perr,
  output logic                               sat_out
);
  import trls_pkg::*;

  localparam int ProdW  = 2 * StateW;
  localparam int DivXW  = StateW + HalfW;
  localparam int DiffW  = DataW + 2;
  localparam logic [ProdW-1:0] MagLimPos = (ProdW'(1) << (StateW - 1)) - ProdW'(1);
  localparam logic [ProdW-1:0] MagLimNeg = ProdW'(1) << (StateW - 1);
  localparam logic [StateW-1:0] SMax = {1'b0, {(StateW-1){1'b1}}};
  localparam logic [StateW-1:0] SMin = {1'b1, {(StateW-1){1'b0}}};
  localparam logic [5:0] DivSteps = 6'(DivXW / 2);

  function automatic logic [StateW-1:0] mag(logic [StateW-1:0] v);
    return v[StateW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [StateW:0] pack_mag(logic neg, logic [ProdW-1:0] m);
    logic             over;
    logic [StateW-1:0] v;
    over = neg ? (m > MagLimNeg) : (m > MagLimPos);
    if (over) v = neg ? SMin : SMax;
    else      v = neg ? (~m[StateW-1:0] + 1'b1) : m[StateW-1:0];
    return {over, v};
  endfunction

  logic [StateW-1:0] rf_r [RfDepth];
  logic [StateW-1:0] rda_r, rdb_r, opb;
  logic [StateW-1:0] phi0_r, phi1_r, y_r, lam;
  logic [DiffW-1:0]  diff;

  // read ports
  always_ff @(posedge clk) begin
    rda_r <= rf_r[cmd.uop.ra];
    rdb_r <= rf_r[cmd.uop.rb];
  end

  assign diff = {{2{meas_in[DataW-1]}}, meas_in} - {{2{base_in[DataW-1]}}, base_in}
              - {{2{offset[DataW-1]}}, offset};
  assign lam  = {{(StateW-FfW-8){1'b0}}, ff, 8'b0};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      phi0_r <= {{(StateW-DataW){abs_in[DataW-1]}}, abs_in};
      phi1_r <= {{(StateW-DataW){tsq_in[DataW-1]}}, tsq_in};
      y_r    <= {{(StateW-DiffW-8){diff[DiffW-1]}}, diff, 8'b0};
    end
  end

  always_comb begin
    unique case (cmd.uop.bsel)
      B_MEM:   opb = rdb_r;
      B_PHI0:  opb = phi0_r;
      B_PHI1:  opb = phi1_r;
      B_Y:     opb = y_r;
      B_LAM:   opb = lam;
      B_FF:    opb = {{(StateW-FfW){1'b0}}, ff};
      default: opb = rdb_r;
    endcase
  end

  // saturating adder
  logic [StateW:0]   alu_sum;
  logic [StateW-1:0] alu_res;
  logic              alu_sat, alu_done;

  always_comb begin
    unique case (cmd.uop.op)
      OP_SUB:  alu_sum = {rda_r[StateW-1], rda_r} - {opb[StateW-1], opb};
      OP_RSUB: alu_sum = {opb[StateW-1], opb} - {rda_r[StateW-1], rda_r};
      default: alu_sum = {rda_r[StateW-1], rda_r} + {opb[StateW-1], opb};
    endcase
    alu_sat = alu_sum[StateW] ^ alu_sum[StateW-1];
    alu_res = alu_sat ? (alu_sum[StateW] ? SMin : SMax) : alu_sum[StateW-1:0];
  end

  assign alu_done = cmd.exec &&
    (cmd.uop.op == OP_ADD || cmd.uop.op == OP_SUB || cmd.uop.op == OP_RSUB);

  // multiplier: low half, high half, accumulate with rounding, scale
  logic [2:0]          mph_r;
  logic [StateW-1:0]   mx_r, my_r;
  logic                mneg_r;
  logic [DivXW-1:0]    pp_r, mul_p;
  logic [ProdW-1:0]    acc_r, rnd, mq;
  logic [StateW:0]     mul_pk;
  logic                mul_done;

  assign mul_p = DivXW'(mx_r) * DivXW'((mph_r == 3'd2) ? my_r[StateW-1:HalfW]
                                                        : my_r[HalfW-1:0]);
  assign rnd   = cmd.uop.s24 ? (ProdW'(1) << (HalfW - 1)) : (ProdW'(1) << (DataFrac - 1));
  assign mq    = cmd.uop.s24 ? (acc_r >> HalfW) : (acc_r >> DataFrac);
  assign mul_pk   = pack_mag(mneg_r, mq);
  assign mul_done = (mph_r == 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mph_r <= 3'd0;
    end else if (cmd.exec && cmd.uop.op == OP_MUL) begin
      mph_r <= 3'd1;
    end else if (mph_r == 3'd4) begin
      mph_r <= 3'd0;
    end else if (mph_r != 3'd0) begin
      mph_r <= mph_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && cmd.uop.op == OP_MUL) begin
      mx_r   <= mag(rda_r);
      my_r   <= mag(opb);
      mneg_r <= rda_r[StateW-1] ^ opb[StateW-1];
    end
    if (mph_r == 3'd1 || mph_r == 3'd2) pp_r <= mul_p;
    if (mph_r == 3'd2) acc_r <= {{(ProdW-DivXW){1'b0}}, pp_r};
    if (mph_r == 3'd3) acc_r <= acc_r + {pp_r, {HalfW{1'b0}}} + rnd;
  end

  // divider: two quotient bits per cycle
  logic              dbusy_r, dspec_r, dneg_r, dspec_sat_r;
  logic [5:0]        dcnt_r;
  logic [DivXW-1:0]  dx_r, dq_r, dx_nxt, dq_nxt, dx_init;
  logic [StateW:0]   drem_r, drem_nxt;
  logic [StateW-1:0] dd_r, dspec_val_r, nmag, dmag;
  logic [StateW:0]   div_pk;
  logic              div_done, div_start;

  assign nmag      = mag(rda_r);
  assign dmag      = mag(opb);
  assign div_start = cmd.exec && cmd.uop.op == OP_DIV;
  assign dx_init   = (cmd.uop.s24 ? {nmag, {HalfW{1'b0}}}
                                  : {{(HalfW-DataFrac){1'b0}}, nmag, {DataFrac{1'b0}}})
                   + {{(HalfW+1){1'b0}}, dmag[StateW-1:1]};

  always_comb begin
    dx_nxt   = dx_r;
    dq_nxt   = dq_r;
    drem_nxt = drem_r;
    for (int k = 0; k < 2; k++) begin
      drem_nxt = {drem_nxt[StateW-1:0], dx_nxt[DivXW-1]};
      dx_nxt   = {dx_nxt[DivXW-2:0], 1'b0};
      if (drem_nxt >= {1'b0, dd_r}) begin
        drem_nxt = drem_nxt - {1'b0, dd_r};
        dq_nxt   = {dq_nxt[DivXW-2:0], 1'b1};
      end else begin
        dq_nxt   = {dq_nxt[DivXW-2:0], 1'b0};
      end
    end
  end

  assign div_pk   = pack_mag(dneg_r, {{(ProdW-DivXW){1'b0}}, dq_r});
  assign div_done = dspec_r || (dbusy_r && dcnt_r == 6'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dspec_r <= 1'b0;
    end else if (div_start) begin
      dspec_r <= (rda_r == '0) || (opb == '0);
      dbusy_r <= (rda_r != '0) && (opb != '0);
    end else begin
      dspec_r <= 1'b0;
      if (div_done) dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      dx_r        <= dx_init;
      dq_r        <= '0;
      drem_r      <= '0;
      dd_r        <= dmag;
      dneg_r      <= rda_r[StateW-1] ^ opb[StateW-1];
      dcnt_r      <= DivSteps;
      dspec_sat_r <= (rda_r != '0);
      dspec_val_r <= (rda_r == '0) ? '0 : (rda_r[StateW-1] ? SMin : SMax);
    end else if (dbusy_r && dcnt_r != 6'd0) begin
      dx_r   <= dx_nxt;
      dq_r   <= dq_nxt;
      drem_r <= drem_nxt;
      dcnt_r <= dcnt_r - 6'd1;
    end
  end

  // write back
  logic              wr_en, wr_sat;
  logic [StateW-1:0] wr_data, d_init;

  assign d_init = {{(StateW-CovW-8){1'b0}}, init_cov, 8'b0};
  assign stat.done = alu_done | mul_done | div_done;
  assign wr_en     = cmd.init_wr | stat.done;

  always_comb begin
    wr_sat = 1'b0;
    priority if (cmd.init_wr) begin
      wr_data = (cmd.uop.dest == R_P0 || cmd.uop.dest == R_P3) ? d_init : '0;
    end else if (alu_done) begin
      wr_data = alu_res;
      wr_sat  = alu_sat;
    end else if (mul_done) begin
      wr_data = mul_pk[StateW-1:0];
      wr_sat  = mul_pk[StateW];
    end else if (dspec_r) begin
      wr_data = dspec_val_r;
      wr_sat  = dspec_sat_r;
    end else begin
      wr_data = div_pk[StateW-1:0];
      wr_sat  = div_pk[StateW];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) rf_r[cmd.uop.dest] <= wr_data;
  end

  logic              sat_r;
  logic [StateW-1:0] c0_r, c1_r, err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.load_in) begin
      sat_r <= 1'b0;
    end else if (stat.done && wr_sat) begin
      sat_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && cmd.uop.dest == R_C0)  c0_r  <= wr_data;
    if (stat.done && cmd.uop.dest == R_C1)  c1_r  <= wr_data;
    if (stat.done && cmd.uop.dest == R_ERR) err_r <= wr_data;
  end

  // error rescale to the data format
  logic [StateW:0]       em;
  logic [StateW-8:0]     eq;
  logic                  eneg, eover;
  logic [DataW-1:0]      eval;
  logic [StateW-1:0]     coeff_one_r, coeff_two_r;
  logic [DataW-1:0]      perr_r;
  logic                  sat_out_r;

  always_comb begin
    eneg  = err_r[StateW-1];
    em    = {1'b0, mag(err_r)} + (StateW+1)'(128);
    eq    = em[StateW:8];
    eover = eneg ? (eq > ((StateW-7)'(1) << (DataW - 1)))
                 : (eq > (((StateW-7)'(1) << (DataW - 1)) - (StateW-7)'(1)));
    if (eover) eval = eneg ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    else       eval = eneg ? (~eq[DataW-1:0] + 1'b1) : eq[DataW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      coeff_one_r <= c0_r;
      coeff_two_r <= c1_r;
      perr_r      <= eval;
      sat_out_r   <= sat_r | eover;
    end
  end

  assign coeff_one = coeff_one_r;
  assign coeff_two = coeff_two_r;
  assign perr      = perr_r;
  assign sat_out   = sat_out_r;

endmodule
`default_nettype wire

/* rtl/core/trls_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trls_ctrl
// Sequencer of the RLS estimator: state reinitialization sweep, item
// handshake and stepping through the update program.
// ----------------------------------------------------------------------------
module trls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               reinit,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output trls_pkg::dp_cmd_t  cmd,
  input  trls_pkg::dp_stat_t stat
);
  import trls_pkg::*;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_EX   = 6'b001000,
    S_WAIT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [PcW-1:0]   pc_r, pc_nxt;
  logic [InitW-1:0] icnt_r, icnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  uop_t             uop;

  assign uop = prog_rom(pc_r);

  always_comb begin
    cmd          = '0;
    cmd.uop      = uop;
    cmd.exec     = (state_r == S_EX);
    cmd.init_wr  = (state_r == S_INIT);
    cmd.load_in  = (state_r == S_IDLE) && in_valid;
    cmd.load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);
    if (state_r == S_INIT) cmd.uop.dest = RfAw'(icnt_r);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    icnt_nxt  = icnt_r;
    unique case (state_r)
      S_INIT: begin
        icnt_nxt = icnt_r + 1'b1;
        if (icnt_r == InitLast) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          pc_nxt    = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_EX;
      S_EX, S_WAIT: begin
        if (stat.done) begin
          if (pc_r == ProgLast) begin
            state_nxt = S_DONE;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_DONE: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
    if (reinit) begin
      state_nxt = S_INIT;
      icnt_nxt  = '0;
    end
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pc_r        <= '0;
      icnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      icnt_r      <= icnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(state_r == S_RD))
    else $error("operation issued without a register read cycle");

  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (state_r == S_EX || state_r == S_WAIT))
    else $error("datapath completion outside an operation");

  a_load_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result word loaded but not offered");

  a_init_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init_wr |-> !in_ready)
    else $error("input accepted during state reinitialization");

endmodule
`default_nettype wire

/* rtl/core/two_parameter_rls_estimator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// two_parameter_rls_estimator
// Two-parameter recursive least squares estimator with forgetting factor for
// a motor power model; fixed point, saturating, one result per input word.
// ----------------------------------------------------------------------------
// Schedule: each accepted input runs the 36-step update program on one
//   shared 48x24 multiplier and one 2-bit-per-cycle divider (6 quotients
//   per item). No new input is taken until the result is loaded into the
//   output register; the next input is taken while that result waits there.
// Reset and every write to the three configuration registers run a state
//   load (covariance diagonal from the register, coefficients zero) with
//   in_ready low.
module two_parameter_rls_estimator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [trls_pkg::DataW-1:0]  in_abs_regressor,
  input  logic signed [trls_pkg::DataW-1:0]  in_torque_sq_regressor,
  input  logic signed [trls_pkg::DataW-1:0]  in_base_power,
  input  logic signed [trls_pkg::DataW-1:0]  in_measured_power,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [trls_pkg::StateW-1:0] out_coeff_one,
  output logic signed [trls_pkg::StateW-1:0] out_coeff_two,
  output logic signed [trls_pkg::DataW-1:0]  out_prediction_error,
  output logic                               out_saturated,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [trls_pkg::CfgAw-1:0]         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import trls_pkg::*;

  logic [FfW-1:0]   ff;
  logic [CovW-1:0]  init_cov;
  logic [DataW-1:0] offset;
  logic             reinit;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  trls_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .ff         (ff),
    .init_cov   (init_cov),
    .offset     (offset),
    .reinit     (reinit)
  );

  trls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .reinit   (reinit),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  trls_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .ff       (ff),
    .init_cov (init_cov),
    .offset   (offset),
    .abs_in   (in_abs_regressor),
    .tsq_in   (in_torque_sq_regressor),
    .base_in  (in_base_power),
    .meas_in  (in_measured_power),
    .coeff_one(out_coeff_one),
    .coeff_two(out_coeff_two),
    .perr     (out_prediction_error),
    .sat_out  (out_saturated)
  );

endmodule
`default_nettype wire

/* bench/two_parameter_rls_estimator_test.sv */
// ----------------------------------------------------------------------------
// Two-parameter RLS estimator testbench
// Drives input words and register writes into the estimator, predicts every
// result with a fixed-point model of its own, and checks each result word
// field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module two_parameter_rls_estimator_test;
  import trls_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [StateW-1:0] coeff_one;
    logic signed [StateW-1:0] coeff_two;
    logic signed [DataW-1:0]  prediction_error;
    logic                     saturated;
  } rls_result_t;

  typedef struct packed {
    logic signed [DataW-1:0] abs_reg;
    logic signed [DataW-1:0] tsq_reg;
    logic signed [DataW-1:0] base;
    logic signed [DataW-1:0] meas;
  } rls_word_t;

  class rls_scoreboard;
    longint      coeff[2];
    longint      cov[4];
    longint      ff;
    longint      cov_init;
    longint      offset;
    bit          sat_hit;
    rls_result_t expected_q[$];
    int          errors;
    int          checked;
    int          sat_seen;

    function logic [63:0] mag(longint a);
      return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function longint from_mag(bit neg, logic [127:0] m, int w);
      logic [127:0] lim;
      lim = (128'd1 << (w - 1)) - (neg ? 128'd0 : 128'd1);
      if (m > lim) begin
        sat_hit = 1;
        m = lim;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function longint clamp(longint v);
      return from_mag(v < 0, {64'd0, mag(v)}, StateW);
    endfunction

    function longint mul_round(longint a, longint b, int s, int w);
      logic [127:0] p;
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      p = (p + (128'd1 << (s - 1))) >> s;
      if (p[127:64] != 0) p = {64'd0, {64{1'b1}}};
      return from_mag((a < 0) != (b < 0), p, w);
    endfunction

    function longint div_round(longint num, longint den, int s);
      logic [127:0] n;
      logic [127:0] q;
      if (num == 0) return 0;
      if (den == 0) return from_mag(num < 0, {64'd0, {64{1'b1}}}, StateW);
      n = ({64'd0, mag(num)} << s) + {65'd0, mag(den) >> 1};
      q = n / {64'd0, mag(den)};
      if (q[127:64] != 0) q = {64'd0, {64{1'b1}}};
      return from_mag((num < 0) != (den < 0), q, StateW);
    endfunction

    function longint to_state(longint v);
      return mul_round(v, 64'sd1 << HalfW, DataFrac, StateW);
    endfunction

    function void reinit();
      longint d;
      d = to_state(cov_init);
      coeff[0] = 0;
      coeff[1] = 0;
      cov[0] = d;
      cov[1] = 0;
      cov[2] = 0;
      cov[3] = d;
    endfunction

    function void reset_regs();
      ff = FfReset;
      cov_init = CovReset;
      offset = longint'($signed(OffsetReset));
      reinit();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == CFG_FF) ff = val[FfW-1:0];
      else if (idx == CFG_COV) cov_init = val[CovW-1:0];
      else if (idx == CFG_OFFSET) offset = longint'($signed(val));
      else return;
      reinit();
    endfunction

    function void note_input(rls_word_t wd);
      longint phi[2], pphi[2], col[2], k[2], np[4];
      longint y, ptp, lam_s, den, yhat, err;
      rls_result_t r;
      sat_hit = 0;
      phi[0] = wd.abs_reg;
      phi[1] = wd.tsq_reg;
      y = to_state(longint'(wd.meas) - longint'(wd.base) - offset);
      for (int i = 0; i < 2; i++) begin
        pphi[i] = clamp(mul_round(cov[i*2], phi[0], DataFrac, StateW)
                      + mul_round(cov[i*2+1], phi[1], DataFrac, StateW));
        col[i] = clamp(mul_round(cov[i], phi[0], DataFrac, StateW)
                     + mul_round(cov[2+i], phi[1], DataFrac, StateW));
      end
      ptp = clamp(mul_round(phi[0], pphi[0], DataFrac, StateW)
                + mul_round(phi[1], pphi[1], DataFrac, StateW));
      lam_s = mul_round(ff, 64'sd1 << HalfW, 16, StateW);
      den = clamp(lam_s + ptp);
      k[0] = div_round(pphi[0], den, HalfW);
      k[1] = div_round(pphi[1], den, HalfW);
      yhat = clamp(mul_round(phi[0], coeff[0], DataFrac, StateW)
                 + mul_round(phi[1], coeff[1], DataFrac, StateW));
      err = clamp(y - yhat);
      for (int i = 0; i < 2; i++)
        coeff[i] = clamp(coeff[i] + mul_round(k[i], err, HalfW, StateW));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          np[i*2+j] = div_round(clamp(cov[i*2+j] - mul_round(k[i], col[j], HalfW, StateW)),
                                ff, 16);
      for (int i = 0; i < 4; i++) cov[i] = np[i];
      r.prediction_error = DataW'(mul_round(err, 64'sd1 << DataFrac, HalfW, DataW));
      r.coeff_one = StateW'(coeff[0]);
      r.coeff_two = StateW'(coeff[1]);
      r.saturated = sat_hit;
      expected_q.push_back(r);
    endfunction

    function void report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endfunction

    function void check_result(rls_result_t got);
      rls_result_t exp_r;
      if (expected_q.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.saturated) sat_seen++;
      if (got.coeff_one !== exp_r.coeff_one)
        report($sformatf("coeff_one %h, expected %h", got.coeff_one, exp_r.coeff_one));
      if (got.coeff_two !== exp_r.coeff_two)
        report($sformatf("coeff_two %h, expected %h", got.coeff_two, exp_r.coeff_two));
      if (got.prediction_error !== exp_r.prediction_error)
        report($sformatf("prediction_error %h, expected %h",
                         got.prediction_error, exp_r.prediction_error));
      if (got.saturated !== exp_r.saturated)
        report($sformatf("saturated %b, expected %b", got.saturated, exp_r.saturated));
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DataW-1:0]  in_abs_regressor;
  logic signed [DataW-1:0]  in_torque_sq_regressor;
  logic signed [DataW-1:0]  in_base_power;
  logic signed [DataW-1:0]  in_measured_power;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [StateW-1:0] out_coeff_one;
  logic signed [StateW-1:0] out_coeff_two;
  logic signed [DataW-1:0]  out_prediction_error;
  logic                     out_saturated;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CfgAw-1:0]         cfg_paddr;
  logic [31:0]              cfg_pwdata;
  logic [31:0]              cfg_prdata;
  logic                     cfg_pready;

  rls_scoreboard sb;
  int            words_sent;
  bit            send_calm;
  bit            hold_req;

  two_parameter_rls_estimator uut (.*);

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CfgAw'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_word(rls_word_t wd);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_abs_regressor       <= wd.abs_reg;
    in_torque_sq_regressor <= wd.tsq_reg;
    in_base_power          <= wd.base;
    in_measured_power      <= wd.meas;
    do @(posedge clk); while (!in_ready);
    sb.note_input(wd);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] small_signed(int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic rls_word_t random_word();
    rls_word_t    wd;
    int unsigned  mode;
    longint       m;
    mode = $urandom_range(0, 19);
    if (mode < 14) begin
      // plausible motor data following a fixed power model plus noise
      wd.abs_reg = $urandom_range(0, 32'h0014_0000);
      wd.tsq_reg = $urandom_range(0, 32'h000a_0000);
      wd.base    = small_signed(32'h0080_0000);
      m = longint'(wd.base) + sb.offset + ((longint'(wd.abs_reg) * 3) >>> 1)
        + (longint'(wd.tsq_reg) * 5) + longint'($signed(small_signed(32'h0001_0000)));
      wd.meas = 32'(m);
    end else if (mode < 17) begin
      wd = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      wd.abs_reg = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      wd.tsq_reg = $urandom_range(0, 1) ? small_signed(255) : 32'h8000_0000;
      wd.base    = $urandom;
      wd.meas    = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    end
    return wd;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
      send_word(random_word());
    end
    send_calm = 1'b0;
  endtask

  // receiver
  initial begin
    int stall;
    int got_words;
    rls_result_t got;
    got_words = 0;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (2500) @(posedge clk);
      end else begin
        stall = ((got_words / 30) % 4 == 1) ? 0 : $urandom_range(0, 6);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.coeff_one        = out_coeff_one;
      got.coeff_two        = out_coeff_two;
      got.prediction_error = out_prediction_error;
      got.saturated        = out_saturated;
      sb.check_result(got);
      got_words++;
    end
  end

  initial begin
    #60000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_regs();
    words_sent = 0;
    send_calm = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_abs_regressor = '0;
    in_torque_sq_regressor = '0;
    in_base_power = '0;
    in_measured_power = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset, field extremes
    send_word({32'h0, 32'h0, 32'h0, 32'h0});
    send_word({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    send_word({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_word({32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff});
    send_word({32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0});
    send_word({32'h0001_0000, 32'h0, 32'h0, 32'h0068_0000});
    send_word({32'h0, 32'h0001_0000, 32'h0010_0000, 32'h0080_0000});
    send_word({32'hffff_ffff, 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa});
    run_random(350);
    drain();

    // lambda 0.9, tiny covariance, most negative offset
    cfg_write(CFG_FF, 32'd58982);
    cfg_write(CFG_COV, 32'd1);
    cfg_write(CFG_OFFSET, 32'h8000_0000);
    send_word({32'h0001_0000, 32'h0001_0000, 32'h0, 32'h7fff_ffff});
    send_word({32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    run_random(300);
    drain();

    // unit lambda, widest covariance, largest offset; receiver holds off
    cfg_write(CFG_FF, 32'd65536);
    cfg_write(CFG_COV, 32'h7fff_ffff);
    cfg_write(CFG_OFFSET, 32'h7fff_ffff);
    send_word({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
    hold_req = 1'b1;
    run_random(300);
    drain();

    // zero lambda: divisor can vanish
    cfg_write(CFG_FF, 32'd0);
    send_word({32'h0, 32'h0, 32'h0, 32'h0});
    send_word({32'h0, 32'h0, 32'h0, 32'h0100_0000});
    send_word({32'h0002_0000, 32'hfffe_0000, 32'h0, 32'h0});
    run_random(150);
    drain();

    // lambda above range, unit covariance, zero offset, spare address ignored
    cfg_write(CFG_FF, 32'hffff_ffff);
    cfg_write(CFG_COV, 32'h0001_0000);
    cfg_write(CFG_OFFSET, 32'h0);
    cfg_write(CFG_SPARE, 32'hdead_beef);
    run_random(150);
    drain();

    // back to the reset values
    cfg_write(CFG_FF, 32'(FfReset));
    cfg_write(CFG_COV, 32'(CovReset));
    cfg_write(CFG_OFFSET, OffsetReset);
    run_random(350);
    drain();
    repeat (400) @(posedge clk);

    $display("run: %0d input words over six register settings, %0d results checked",
             words_sent, sb.checked);
    $display("run: %0d results flagged saturated, one long receiver hold-off",
             sb.sat_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
